FILE: rtl/core/tlvrs_pkg.sv
`timescale 1ns / 1ps

package tlvrs_pkg;

  // Store geometry. The count byte sits at LAST_ADDR and is kept in a register,
  // so the memory holds only the data area below it.
  localparam int LAST_ADDR = 1023;
  localparam int MEM_DEPTH = LAST_ADDR;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  // Wide enough for a header address plus a record length or an offset.
  localparam int ADDR_W    = $clog2(LAST_ADDR + 512);

  localparam logic [ADDR_W-1:0] MEM_TOP    = ADDR_W'(LAST_ADDR);
  localparam logic [ADDR_W-1:0] WALK_LIMIT = ADDR_W'(LAST_ADDR - 2);
  localparam logic [ADDR_W-1:0] FIT_LIMIT  = ADDR_W'(LAST_ADDR - 1);

  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [7:0] MIN_LEN   = 8'd2;

  // Operation codes.
  localparam logic [1:0] FN_READ   = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_DATA   = 2'd2;
  localparam logic [1:0] FN_DELETE = 2'd3;

  // Status codes.
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NOTFOUND = 3'd1;
  localparam logic [2:0] STS_EXISTS   = 3'd2;
  localparam logic [2:0] STS_NOSPACE  = 3'd3;
  localparam logic [2:0] STS_BAD      = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rec_id;
    logic [7:0] rec_len;
    logic [7:0] offset;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_len;
    logic [7:0] read_byte;
    logic [7:0] record_count;
  } out_t;

  // One read and one write request to the byte memory per cycle.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WSTART,
    S_WHDR,
    S_WLEN,
    S_DISPATCH,
    S_RDWAIT,
    S_ADATA,
    S_AHDR,
    S_SHIFT,
    S_ZERO,
    S_RESP
  } seq_state_t;

endpackage

FILE: rtl/core/tlv_record_store_core.sv
`timescale 1ns / 1ps

// Channel   Ports                          Moves
// input     in_valid, in_stall, in_item    one operation item (in_t)
// result    out_valid, out_stall, out_item one result item (out_t)
//
// After reset the memory is cleared, one byte a cycle; in_stall is high.
// Read, append header and delete walk the record headers, reading the id and
// length byte of each. Delete then moves the later bytes down and zeroes the
// bytes it frees; append header writes every byte of the new record; append
// data needs no walk. The byte memory has a single read and a single write
// port.
// A finished result sits in an output register, so the next item is accepted
// while out_stall holds the previous one.
module tlv_record_store_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tlvrs_pkg::in_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output tlvrs_pkg::out_t out_item
);
  import tlvrs_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] rd_data;
  logic       res_valid;
  logic       res_ready;
  out_t       res_item;

  // Byte memory holding the packed records.
  tlvrs_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Operation sequencer.
  tlvrs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready)
  );

  // Result register.
  tlvrs_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // An accepted item keeps the input side stalled while it is worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in progress");

  // A result handed to the output register is not offered twice.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> !res_valid)
    else $error("result offered again after handoff");

  // The output register fills only from a handoff.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid && res_ready))
    else $error("output valid without a result handoff");

  // A delivered status is always a defined code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status <= STS_BAD))
    else $error("undefined status code on output");

endmodule

FILE: rtl/core/tlvrs_mem.sv
`timescale 1ns / 1ps

module tlvrs_mem (
  input  logic               clk,
  input  tlvrs_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);
  import tlvrs_pkg::*;

  logic [7:0] ram [MEM_DEPTH];
  logic [7:0] q_r;
  logic       oob_r;

  // Writes outside the data area are dropped.
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr < MEM_TOP)) begin
      ram[req.wr_addr[MEM_AW-1:0]] <= req.wr_data;
    end
  end

  // Registered read; addresses outside the data area read as zero.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      q_r   <= ram[req.rd_addr[MEM_AW-1:0]];
      oob_r <= (req.rd_addr >= MEM_TOP);
    end
  end

  assign rd_data = oob_r ? 8'd0 : q_r;

endmodule

FILE: rtl/core/tlvrs_seq.sv
`timescale 1ns / 1ps

module tlvrs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tlvrs_pkg::in_t      in_item,
  output logic                in_stall,
  input  logic [7:0]          rd_data,
  output tlvrs_pkg::mem_req_t mem_req,
  output logic                res_valid,
  output tlvrs_pkg::out_t     res_item,
  input  logic                res_ready
);
  import tlvrs_pkg::*;

  seq_state_t state_r, state_nxt;

  in_t               item_r, item_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [MEM_AW-1:0] pbase_r, pbase_nxt;
  logic [7:0]        plen_r, plen_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic [ADDR_W-1:0] a_r, a_nxt;
  logic [7:0]        n_r, n_nxt;
  logic [7:0]        hid_r, hid_nxt;
  logic              found_r, found_nxt;
  logic [MEM_AW-1:0] faddr_r, faddr_nxt;
  logic [7:0]        flen_r, flen_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic              wv_r, wv_nxt;
  logic [7:0]        k_r, k_nxt;
  logic [MEM_AW-1:0] clr_r, clr_nxt;
  logic [2:0]        sts_r, sts_nxt;
  logic [7:0]        rbyte_r, rbyte_nxt;

  logic [ADDR_W-1:0] a_step;
  logic [7:0]        n_step;
  logic              cur_ok;
  logic              step_ok;
  logic              hit;
  logic [ADDR_W-1:0] rec_end;
  logic [ADDR_W-1:0] flen_a;
  logic [ADDR_W-1:0] off_a;
  logic [ADDR_W-1:0] rlen_a;
  logic              room_bad;
  logic              app_ok;
  logic              data_bad;
  logic              read_ok;

  // Header walk arithmetic and the checks shared by several states.
  assign a_step   = a_r + ADDR_W'(rd_data);
  assign n_step   = n_r + 8'd1;
  assign cur_ok   = (n_r < count_r) && (a_r < WALK_LIMIT);
  assign step_ok  = (n_step < count_r) && (a_step < WALK_LIMIT);
  assign hit      = !found_r && (hid_r == item_r.rec_id);
  assign flen_a   = ADDR_W'(flen_r);
  assign off_a    = ADDR_W'(item_r.offset);
  assign rlen_a   = ADDR_W'(item_r.rec_len);
  assign rec_end  = ADDR_W'(faddr_r) + flen_a;
  assign room_bad = (count_r >= COUNT_MAX) || (a_r >= WALK_LIMIT) ||
                    ((a_r + rlen_a) >= FIT_LIMIT);
  assign app_ok   = (item_r.rec_len >= MIN_LEN) && !found_r && !room_bad;
  assign data_bad = !pvalid_r || (item_r.offset < MIN_LEN) || (item_r.offset >= plen_r);
  assign read_ok  = found_r && (item_r.offset < flen_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == MEM_AW'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = (in_item.func == FN_DATA) ? S_ADATA : S_WSTART;
      end
      S_WSTART: state_nxt = cur_ok ? S_WHDR : S_DISPATCH;
      S_WHDR:   state_nxt = S_WLEN;
      S_WLEN:   state_nxt = step_ok ? S_WHDR : S_DISPATCH;
      S_DISPATCH: begin
        unique case (item_r.func)
          FN_READ:   state_nxt = read_ok ? S_RDWAIT : S_RESP;
          FN_APPEND: state_nxt = app_ok ? S_AHDR : S_RESP;
          FN_DELETE: state_nxt = found_r ? S_SHIFT : S_RESP;
          default:   state_nxt = S_RESP;
        endcase
      end
      S_RDWAIT: state_nxt = S_RESP;
      S_ADATA:  state_nxt = S_RESP;
      S_AHDR: begin
        if (k_r == (item_r.rec_len - 8'd1)) state_nxt = S_RESP;
      end
      S_SHIFT: begin
        if ((p_r >= end_r) && !wv_r) state_nxt = S_ZERO;
      end
      S_ZERO: begin
        if (p_r >= end_r) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory requests, datapath updates and the result.
  always_comb begin
    item_nxt   = item_r;
    count_nxt  = count_r;
    pbase_nxt  = pbase_r;
    plen_nxt   = plen_r;
    pvalid_nxt = pvalid_r;
    a_nxt      = a_r;
    n_nxt      = n_r;
    hid_nxt    = hid_r;
    found_nxt  = found_r;
    faddr_nxt  = faddr_r;
    flen_nxt   = flen_r;
    end_nxt    = end_r;
    p_nxt      = p_r;
    wa_nxt     = wa_r;
    wv_nxt     = wv_r;
    k_nxt      = k_r;
    clr_nxt    = clr_r;
    sts_nxt    = sts_r;
    rbyte_nxt  = rbyte_r;
    mem_req    = '0;
    res_valid  = 1'b0;
    in_stall   = (state_r != S_IDLE);

    unique case (state_r)
      // Sweep the whole memory to zero after reset.
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ADDR_W'(clr_r);
        mem_req.wr_data = 8'd0;
        clr_nxt         = clr_r + MEM_AW'(1);
      end
      // Take a new item and start the header walk from address zero.
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          a_nxt     = '0;
          n_nxt     = '0;
          found_nxt = 1'b0;
          flen_nxt  = '0;
          sts_nxt   = STS_OK;
          rbyte_nxt = '0;
          if (in_item.func == FN_DELETE) pvalid_nxt = 1'b0;
        end
      end
      S_WSTART: begin
        if (cur_ok) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = a_r;
        end
      end
      // The id byte arrives; fetch the length byte.
      S_WHDR: begin
        hid_nxt         = rd_data;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = a_r + ADDR_W'(1);
      end
      // The length byte arrives; note a first match and step to the next header.
      S_WLEN: begin
        if (hit) begin
          found_nxt = 1'b1;
          faddr_nxt = a_r[MEM_AW-1:0];
          flen_nxt  = rd_data;
        end
        a_nxt = a_step;
        n_nxt = n_step;
        if (step_ok) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = a_step;
        end
      end
      // The walk is over: a_r holds the end of the used region.
      S_DISPATCH: begin
        unique case (item_r.func)
          FN_READ: begin
            if (!found_r) begin
              sts_nxt = STS_NOTFOUND;
            end else if (read_ok) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = ADDR_W'(faddr_r) + off_a;
            end else begin
              sts_nxt = STS_BAD;
            end
          end
          FN_APPEND: begin
            if (item_r.rec_len < MIN_LEN) begin
              sts_nxt = STS_BAD;
            end else if (found_r) begin
              sts_nxt = STS_EXISTS;
            end else if (room_bad) begin
              sts_nxt = STS_NOSPACE;
            end else begin
              end_nxt    = a_r;
              k_nxt      = '0;
              count_nxt  = count_r + 8'd1;
              pbase_nxt  = a_r[MEM_AW-1:0];
              plen_nxt   = item_r.rec_len;
              pvalid_nxt = 1'b1;
            end
          end
          FN_DELETE: begin
            if (!found_r) begin
              sts_nxt = STS_NOTFOUND;
            end else begin
              end_nxt = (a_r < rec_end) ? rec_end : a_r;
              p_nxt   = rec_end;
              wv_nxt  = 1'b0;
            end
          end
          default: begin
            sts_nxt = sts_r;
          end
        endcase
      end
      S_RDWAIT: begin
        rbyte_nxt = rd_data;
      end
      // Append data needs no walk: check against the pending record and write.
      S_ADATA: begin
        if (data_bad) begin
          sts_nxt = STS_BAD;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ADDR_W'(pbase_r) + off_a;
          mem_req.wr_data = item_r.data_byte;
        end
      end
      // Lay down the new record: id, length, then zeroed data bytes.
      S_AHDR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = end_r + ADDR_W'(k_r);
        if (k_r == 8'd0) begin
          mem_req.wr_data = item_r.rec_id;
        end else if (k_r == 8'd1) begin
          mem_req.wr_data = item_r.rec_len;
        end else begin
          mem_req.wr_data = 8'd0;
        end
        k_nxt = k_r + 8'd1;
      end
      // Compaction: read one byte ahead, write it a record length lower next cycle.
      S_SHIFT: begin
        if (wv_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = wa_r;
          mem_req.wr_data = rd_data;
        end
        if (p_r < end_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_r;
          wv_nxt          = 1'b1;
          wa_nxt          = p_r - flen_a;
          p_nxt           = p_r + ADDR_W'(1);
        end else begin
          wv_nxt = 1'b0;
          if (!wv_r) p_nxt = end_r - flen_a;
        end
      end
      // Zero the freed tail, then drop the count.
      S_ZERO: begin
        if (p_r < end_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = p_r;
          mem_req.wr_data = 8'd0;
          p_nxt           = p_r + ADDR_W'(1);
        end else begin
          count_nxt = count_r - 8'd1;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res_item.status       = sts_r;
  assign res_item.found_len    = (item_r.func == FN_READ) ? flen_r : 8'd0;
  assign res_item.read_byte    = rbyte_r;
  assign res_item.record_count = count_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      count_r  <= '0;
      pbase_r  <= '0;
      plen_r   <= '0;
      pvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      pbase_r  <= pbase_nxt;
      plen_r   <= plen_nxt;
      pvalid_r <= pvalid_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    a_r     <= a_nxt;
    n_r     <= n_nxt;
    hid_r   <= hid_nxt;
    found_r <= found_nxt;
    faddr_r <= faddr_nxt;
    flen_r  <= flen_nxt;
    end_r   <= end_nxt;
    p_r     <= p_nxt;
    wa_r    <= wa_nxt;
    wv_r    <= wv_nxt;
    k_r     <= k_nxt;
    sts_r   <= sts_nxt;
    rbyte_r <= rbyte_nxt;
  end

endmodule

FILE: rtl/core/tlvrs_outreg.sv
`timescale 1ns / 1ps

module tlvrs_outreg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  tlvrs_pkg::out_t res_item,
  output logic            res_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output tlvrs_pkg::out_t out_item
);
  import tlvrs_pkg::*;

  logic out_valid_r;
  out_t out_item_r;

  // The register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: dv/tb_tlv_record_store_core.sv
`timescale 1ns / 1ps

module tb_tlv_record_store_core;

  import tlvrs_pkg::*;

  // Tracks the byte store the same way the block does and keeps the results
  // that accepted operations are due to produce, oldest first.
  class tlv_store_checker;
    logic [7:0]  image [0:LAST_ADDR];
    int unsigned open_base;
    int unsigned open_len;
    bit          open_valid;
    out_t        expected_results [$];
    int unsigned mismatch_count;
    int unsigned results_seen;

    function new();
      foreach (image[i]) image[i] = 8'd0;
      open_base      = 0;
      open_len       = 0;
      open_valid     = 1'b0;
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    // peek reads addresses at or above the count byte as zero and poke never writes them.
    function logic [7:0] peek(int unsigned a);
      return (a < LAST_ADDR) ? image[a] : 8'd0;
    endfunction

    function void poke(int unsigned a, logic [7:0] v);
      if (a < LAST_ADDR) image[a] = v;
    endfunction

    function int unsigned count_now();
      return int'(image[LAST_ADDR]);
    endfunction

    // Header walk over the first count records, stopping at the walk limit.
    function bit locate(logic [7:0] id, output int unsigned addr, output int unsigned len);
      int unsigned a;
      a    = 0;
      addr = 0;
      len  = 0;
      for (int unsigned i = 0; i < count_now(); i++) begin
        if (a >= LAST_ADDR - 2) return 1'b0;
        if (peek(a) == id) begin
          addr = a;
          len  = int'(peek(a + 1));
          return 1'b1;
        end
        a += int'(peek(a + 1));
      end
      return 1'b0;
    endfunction

    // Header of the k-th stored record, if the walk reaches it.
    function bit nth_header(int unsigned k, output logic [7:0] id, output int unsigned len);
      int unsigned a;
      a   = 0;
      id  = 8'd0;
      len = 0;
      for (int unsigned i = 0; i < count_now(); i++) begin
        if (a >= LAST_ADDR - 2) return 1'b0;
        if (i == k) begin
          id  = peek(a);
          len = int'(peek(a + 1));
          return 1'b1;
        end
        a += int'(peek(a + 1));
      end
      return 1'b0;
    endfunction

    // First free address after the stored records.
    function int unsigned used_end();
      int unsigned a;
      a = 0;
      for (int unsigned i = 0; i < count_now() && a < LAST_ADDR - 2; i++)
        a += int'(peek(a + 1));
      return a;
    endfunction

    // Applies one operation to the image and returns the result it produces.
    function out_t apply_op(in_t it);
      out_t        r;
      int unsigned addr;
      int unsigned len;
      int unsigned tail;
      r        = '0;
      r.status = STS_OK;
      case (it.func)
        FN_READ: begin
          if (!locate(it.rec_id, addr, len)) begin
            r.status = STS_NOTFOUND;
          end else begin
            r.found_len = 8'(len);
            if (it.offset < len) r.read_byte = peek(addr + it.offset);
            else r.status = STS_BAD;
          end
        end
        FN_APPEND: begin
          if (it.rec_len < MIN_LEN) begin
            r.status = STS_BAD;
          end else if (locate(it.rec_id, addr, len)) begin
            r.status = STS_EXISTS;
          end else begin
            tail = used_end();
            if (count_now() >= COUNT_MAX || tail >= LAST_ADDR - 2 ||
                tail + it.rec_len >= LAST_ADDR - 1) begin
              r.status = STS_NOSPACE;
            end else begin
              // Reserve the record with zeroed data; it becomes the open append.
              poke(tail, it.rec_id);
              poke(tail + 1, it.rec_len);
              for (int unsigned i = 2; i < it.rec_len; i++) poke(tail + i, 8'd0);
              image[LAST_ADDR] = image[LAST_ADDR] + 8'd1;
              open_base  = tail;
              open_len   = int'(it.rec_len);
              open_valid = 1'b1;
            end
          end
        end
        FN_DATA: begin
          if (!open_valid || it.offset < 2 || it.offset >= open_len) r.status = STS_BAD;
          else poke(open_base + it.offset, it.data_byte);
        end
        default: begin
          // Delete always closes the open append, found or not.
          open_valid = 1'b0;
          if (!locate(it.rec_id, addr, len)) begin
            r.status = STS_NOTFOUND;
          end else begin
            tail = used_end();
            if (tail < addr + len) tail = addr + len;
            for (int unsigned i = addr; i + len < tail; i++) poke(i, peek(i + len));
            for (int unsigned i = tail - len; i < tail; i++) poke(i, 8'd0);
            image[LAST_ADDR] = image[LAST_ADDR] - 8'd1;
          end
        end
      endcase
      r.record_count = image[LAST_ADDR];
      return r;
    endfunction

    function void note_op(in_t it);
      expected_results.push_back(apply_op(it));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH result %0d: %s", results_seen, msg);
      mismatch_count++;
    endtask

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.found_len !== want.found_len)
          report_mismatch($sformatf("found_len %0d, expected %0d",
                                    got.found_len, want.found_len));
        if (got.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte %0d, expected %0d",
                                    got.read_byte, want.read_byte));
        if (got.record_count !== want.record_count)
          report_mismatch($sformatf("record_count %0d, expected %0d",
                                    got.record_count, want.record_count));
      end
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  tlv_store_checker sb;
  int unsigned      items_sent = 0;
  bit               calm       = 1'b0;

  tlv_record_store_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle cycles before an item or while holding a result; none in calm stretches.
  function int unsigned pause_cycles();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function in_t make_op(logic [1:0] f, logic [7:0] id, logic [7:0] len,
                        logic [7:0] off, logic [7:0] dat);
    in_t it;
    it.func      = f;
    it.rec_id    = id;
    it.rec_len   = len;
    it.offset    = off;
    it.data_byte = dat;
    return it;
  endfunction

  // An id that no stored record carries, searched from a random start.
  function logic [7:0] fresh_id();
    logic [7:0]  id;
    int unsigned a;
    int unsigned l;
    id = 8'($urandom_range(0, 255));
    for (int i = 0; i < 256; i++) begin
      if (!sb.locate(id, a, l)) return id;
      id = id + 8'd1;
    end
    return id;
  endfunction

  // Header of a randomly chosen stored record.
  function bit pick_stored(output logic [7:0] id, output int unsigned len);
    id  = 8'd0;
    len = 0;
    if (sb.count_now() == 0) return 1'b0;
    return sb.nth_header($urandom_range(0, sb.count_now() - 1), id, len);
  endfunction

  // Presents one item after a random gap and holds it until it is taken.
  task send_op(in_t it);
    int unsigned gap;
    gap = pause_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(it);
    items_sent++;
  endtask

  task wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Hand-picked operations: empty store, bad lengths and offsets, full store,
  // duplicate ids, dropped appends and deletes at the front, middle and end.
  task run_directed();
    send_op(make_op(FN_READ,   8'h00, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd2,   8'h11));
    send_op(make_op(FN_DELETE, 8'h05, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h07, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h07, 8'd1,   8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h00, 8'd2,   8'd0,   8'd0));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd2,   8'h22));
    send_op(make_op(FN_APPEND, 8'hFF, 8'd255, 8'd0,   8'd0));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd2,   8'hFF));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd254, 8'hA5));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd1,   8'h33));
    send_op(make_op(FN_READ,   8'hFF, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_READ,   8'hFF, 8'd0,   8'd254, 8'd0));
    send_op(make_op(FN_READ,   8'h00, 8'd0,   8'd2,   8'd0));
    send_op(make_op(FN_APPEND, 8'h00, 8'd9,   8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h01, 8'd255, 8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h02, 8'd255, 8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h03, 8'd255, 8'd0,   8'd0));
    send_op(make_op(FN_APPEND, 8'h03, 8'd254, 8'd0,   8'd0));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd253, 8'h5A));
    send_op(make_op(FN_APPEND, 8'h04, 8'd2,   8'd0,   8'd0));
    send_op(make_op(FN_DELETE, 8'hFF, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_READ,   8'h03, 8'd0,   8'd253, 8'd0));
    send_op(make_op(FN_DELETE, 8'h00, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_DELETE, 8'h03, 8'd0,   8'd0,   8'd0));
    send_op(make_op(FN_DATA,   8'h00, 8'd0,   8'd2,   8'h44));
  endtask

  // One random step: mostly well-formed appends with their data, reads and
  // deletes of stored records, and some fully random items as noise.
  task random_round();
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    logic [7:0]  id;
    logic [7:0]  rlen;
    logic [7:0]  off;
    if ($urandom_range(0, 19) == 0) calm = !calm;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 3) != 0 || !pick_stored(id, len)) id = fresh_id();
      n = $urandom_range(0, 19);
      if (n < 15) rlen = 8'($urandom_range(2, 16));
      else if (n < 19) rlen = 8'($urandom_range(17, 255));
      else rlen = 8'($urandom_range(0, 1));
      send_op(make_op(FN_APPEND, id, rlen, 8'($urandom), 8'($urandom)));
      repeat ($urandom_range(0, 4)) begin
        if (rlen > 2 && $urandom_range(0, 9) != 0) off = 8'($urandom_range(2, rlen - 1));
        else off = 8'($urandom_range(0, 255));
        send_op(make_op(FN_DATA, 8'($urandom), 8'($urandom), off, 8'($urandom)));
      end
    end else if (pick < 60) begin
      if ($urandom_range(0, 4) == 0 || !pick_stored(id, len)) begin
        id  = 8'($urandom_range(0, 255));
        len = 2;
      end
      if ($urandom_range(0, 6) != 0) off = 8'($urandom_range(0, len - 1));
      else off = 8'($urandom_range(0, 255));
      send_op(make_op(FN_READ, id, 8'($urandom), off, 8'($urandom)));
    end else if (pick < 75) begin
      if ($urandom_range(0, 4) == 0 || !pick_stored(id, len)) id = 8'($urandom_range(0, 255));
      send_op(make_op(FN_DELETE, id, 8'($urandom), 8'($urandom), 8'($urandom)));
    end else begin
      send_op(make_op(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom)));
    end
  endtask

  // Empties the store, then fills it with short records up to the count limit,
  // reading back now and then, and finally pokes at the full store.
  task run_fill();
    logic [7:0]  id;
    logic [7:0]  rlen;
    int unsigned len;
    while (sb.count_now() != 0) begin
      void'(pick_stored(id, len));
      send_op(make_op(FN_DELETE, id, 8'($urandom), 8'($urandom), 8'($urandom)));
    end
    while (sb.count_now() < COUNT_MAX) begin
      rlen = 8'($urandom_range(2, 3));
      send_op(make_op(FN_APPEND, fresh_id(), rlen, 8'($urandom), 8'($urandom)));
      if (rlen == 8'd3 && $urandom_range(0, 15) == 0)
        send_op(make_op(FN_DATA, 8'($urandom), 8'($urandom), 8'd2, 8'($urandom)));
      if ($urandom_range(0, 63) == 0 && pick_stored(id, len))
        send_op(make_op(FN_READ, id, 8'($urandom), 8'($urandom_range(0, len - 1)),
                        8'($urandom)));
    end
    send_op(make_op(FN_APPEND, fresh_id(), 8'd2, 8'd0, 8'd0));
    void'(pick_stored(id, len));
    send_op(make_op(FN_APPEND, id, 8'd2, 8'd0, 8'd0));
    void'(sb.nth_header(COUNT_MAX - 1, id, len));
    send_op(make_op(FN_READ, id, 8'd0, 8'd1, 8'd0));
    repeat (4) begin
      void'(pick_stored(id, len));
      send_op(make_op(FN_DELETE, id, 8'd0, 8'd0, 8'd0));
      send_op(make_op(FN_READ, id, 8'd0, 8'd0, 8'd0));
    end
    send_op(make_op(FN_APPEND, fresh_id(), 8'd4, 8'd0, 8'd0));
    send_op(make_op(FN_DATA, 8'd0, 8'd0, 8'd3, 8'($urandom)));
  endtask

  // Result side: after each taken result, hold off for a random number of cycles.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        hold = pause_cycles();
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Main sequence.
  initial begin : stimulus
    int unsigned random_goal;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    in_valid <= 1'b0;
    wait_drained();
    random_goal = items_sent + 16;
    while (items_sent < random_goal) random_round();
    in_valid <= 1'b0;
    wait_drained();
    calm = 1'b0;
    run_fill();
    in_valid <= 1'b0;
    wait_drained();
    repeat (2000) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
